// File: src/pig_pkg.sv
// Shared types and constants for the primitive index generator.
// No dependencies; every other file but pig_queue imports this package.
`timescale 1ns / 1ps
package pig_pkg;

    // Triangle count field: a strip or fan of at most 66 points gives 64.
    localparam int CNT_W = 7;
    localparam int CFG_IDX_W = 1;

    // Request opcodes
    localparam logic [2:0] OP_TRIANGLE = 3'd0;
    localparam logic [2:0] OP_QUAD     = 3'd1;
    localparam logic [2:0] OP_STRIP    = 3'd2;
    localparam logic [2:0] OP_FAN      = 3'd3;
    localparam logic [2:0] OP_CLEAR    = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_FEW  = 3'd1;
    localparam logic [2:0] ST_MANY = 3'd2;
    localparam logic [2:0] ST_IOVF = 3'd3;
    localparam logic [2:0] ST_VOVF = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_CAP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_CAP  = 1'd1;

    localparam logic [15:0] VERTEX_CAP_RST = 16'd4096;
    localparam logic [15:0] INDEX_CAP_RST  = 16'd6144;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] point_count;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic        tri_valid;
        logic [15:0] base_vertex;
        logic [15:0] index_a;
        logic [15:0] index_b;
        logic [15:0] index_c;
        logic [15:0] vertex_count;
        logic [15:0] index_count;
        logic        last;
    } t_res;

    // Classified request handed from the front end to the back end.
    // ntri of zero means a single result without a triangle.
    typedef struct packed {
        logic [2:0]       status;
        logic             strip;
        logic [CNT_W-1:0] ntri;
        logic [15:0]      base;
        logic [15:0]      vcnt;
        logic [15:0]      icnt;
    } t_cmd;

endpackage

// File: src/pig_front.sv
// Front end: capacity registers, pending counters, request checks.
// Depends on pig_pkg.
`timescale 1ns / 1ps
module pig_front #(
    parameter int MAX_POINTS = 66
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pig_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [15:0]                    i_cfg_data,
    input  logic                           i_accept,
    input  pig_pkg::t_req                  i_req,
    output pig_pkg::t_cmd                  o_cmd
);
    import pig_pkg::*;

    logic [15:0]      r_vcap, r_icap, r_vcnt, r_icnt;
    logic [15:0]      n_vcnt, n_icnt;
    logic [15:0]      nv;
    logic [CNT_W-1:0] ntri;
    logic [CNT_W+1:0] need_idx;
    logic [16:0]      idx_sum, vtx_sum;
    logic             is_sf;

    always_comb begin
        is_sf = (i_req.op == OP_STRIP) || (i_req.op == OP_FAN);
        case (i_req.op)
            OP_TRIANGLE: begin
                nv   = 16'd3;
                ntri = CNT_W'(1);
            end
            OP_QUAD: begin
                nv   = 16'd4;
                ntri = CNT_W'(2);
            end
            default: begin
                nv   = i_req.point_count;
                ntri = i_req.point_count[CNT_W-1:0] - CNT_W'(2);
            end
        endcase
        need_idx = {2'b00, ntri} + {1'b0, ntri, 1'b0};
        idx_sum  = {1'b0, r_icnt} + 17'(need_idx);
        vtx_sum  = {1'b0, r_vcnt} + {1'b0, nv};

        n_vcnt       = r_vcnt;
        n_icnt       = r_icnt;
        o_cmd.status = ST_OK;
        o_cmd.strip  = (i_req.op == OP_STRIP);
        o_cmd.ntri   = '0;
        o_cmd.base   = '0;
        if (i_req.op == OP_CLEAR) begin
            n_vcnt = '0;
            n_icnt = '0;
        end else if (i_req.op > OP_CLEAR) begin
            // unknown opcode: report counters, change nothing
        end else if (is_sf && (i_req.point_count < 16'd3)) begin
            o_cmd.status = ST_FEW;
        end else if (is_sf && (i_req.point_count > 16'(MAX_POINTS))) begin
            o_cmd.status = ST_MANY;
        end else if (idx_sum > {1'b0, r_icap}) begin
            o_cmd.status = ST_IOVF;
        end else if (vtx_sum > {1'b0, r_vcap}) begin
            o_cmd.status = ST_VOVF;
        end else begin
            o_cmd.ntri = ntri;
            o_cmd.base = r_vcnt;
            n_vcnt     = vtx_sum[15:0];
            n_icnt     = idx_sum[15:0];
        end
        o_cmd.vcnt = n_vcnt;
        o_cmd.icnt = n_icnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcap <= VERTEX_CAP_RST;
            r_icap <= INDEX_CAP_RST;
            r_vcnt <= '0;
            r_icnt <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == CFG_VERTEX_CAP)) begin
                r_vcap <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == CFG_INDEX_CAP)) begin
                r_icap <= i_cfg_data;
            end
            if (i_accept) begin
                r_vcnt <= n_vcnt;
                r_icnt <= n_icnt;
            end
        end
    end

endmodule

// File: src/pig_queue.sv
// Short command queue between front and back end, flop based.
// Depends on pig_pkg only by convention; payload width is a parameter.
`timescale 1ns / 1ps
module pig_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// File: src/pig_back.sv
// Back end: walks a command's triangles and drives the result register.
// Depends on pig_pkg.
`timescale 1ns / 1ps
module pig_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  pig_pkg::t_cmd  i_q_data,
    output logic           o_q_pop,
    output logic           o_empty,
    input  logic           i_pop,
    output pig_pkg::t_res  o_res
);
    import pig_pkg::*;

    logic             r_busy, r_out_valid;
    t_cmd             r_cmd;
    logic [CNT_W-1:0] r_t;
    t_res             r_out;
    logic             slot_free, emit, is_last, has_tri;
    logic [15:0]      t_base;
    t_res             n_out;

    assign slot_free = !r_out_valid || i_pop;
    assign emit      = r_busy && slot_free;
    assign o_q_pop   = !r_busy && !i_q_empty;
    assign has_tri   = (r_cmd.ntri != '0);
    assign is_last   = !has_tri || ((r_t + CNT_W'(1)) == r_cmd.ntri);
    assign t_base    = r_cmd.base + {{(16 - CNT_W){1'b0}}, r_t};
    assign o_empty   = !r_out_valid;
    assign o_res     = r_out;

    always_comb begin
        n_out.status       = r_cmd.status;
        n_out.tri_valid    = has_tri;
        n_out.base_vertex  = has_tri ? r_cmd.base : 16'd0;
        n_out.index_a      = !has_tri ? 16'd0 : (r_cmd.strip ? t_base : r_cmd.base);
        n_out.index_b      = has_tri ? t_base + 16'd1 : 16'd0;
        n_out.index_c      = has_tri ? t_base + 16'd2 : 16'd0;
        n_out.vertex_count = r_cmd.vcnt;
        n_out.index_count  = r_cmd.icnt;
        n_out.last         = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_data;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_t         <= '0;
        end else begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_t    <= '0;
            end else if (emit) begin
                if (is_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_t <= r_t + CNT_W'(1);
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: src/primitive_index_generator.sv
// Top level of the primitive index generator: front end, command queue, back end.
// Depends on pig_pkg, pig_front, pig_queue and pig_back.
`timescale 1ns / 1ps
// Turns primitive requests (triangle, quad, strip, fan, counter clear) into a
// stream of triangle-list results. The front end checks each request against the
// pending vertex and index counters and the two capacity registers, updates the
// counters in the cycle the request is taken, and queues one command. The back
// end expands that command into one result per triangle (or one status-only
// result) held in an output register. Timing: the front end takes a request per
// cycle while the two-entry command queue has room; the back end loads one
// command, then writes its results into the output register one by one, holding
// while that register is full and not popped, and loads the next command only
// after the last result of the current one has been written. After reset the
// counters are zero, vertex capacity is 4096 and index capacity 6144. The user
// must write capacities via the cfg port while idle; the block does not check it.
module primitive_index_generator #(
    parameter int MAX_POINTS = 66
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [pig_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [15:0]                    i_cfg_data,
    // request side
    input  logic                           push,
    output logic                           full,
    input  pig_pkg::t_req                  i_req,
    // result side
    output logic                           empty,
    input  logic                           pop,
    output pig_pkg::t_res                  o_res
);
    import pig_pkg::*;

    logic  accept;
    t_cmd  front_cmd, q_cmd;
    logic  q_empty, q_pop;

    // a request is taken whenever the queue has a free slot
    assign accept = push && !full;

    pig_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_req      (i_req),
        .o_cmd      (front_cmd)
    );

    pig_queue #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_cmd)
    );

    pig_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_cmd),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_res     (o_res)
    );

    // a result that is not the last of its request must carry a triangle
    a_mid_is_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_res.last) |-> o_res.tri_valid)
        else $error("non-final result without a triangle");

    // a rejected request gives exactly one status-only result
    a_reject_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_res.status != ST_OK)) |-> (o_res.last && !o_res.tri_valid))
        else $error("rejected request produced a triangle");

    // consecutive vertices of a generated triangle
    a_tri_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.tri_valid) |-> (o_res.index_c == o_res.index_b + 16'd1))
        else $error("triangle indices out of order");

endmodule

// File: test/tb_primitive_index_generator.sv
// Self-checking testbench for primitive_index_generator.
// Depends on pig_pkg and the generator RTL; needs no other files.
`timescale 1ns / 1ps
// Requests go in through the push/full side and results come out through the
// empty/pop side. A clocked driver offers requests from a backlog that the
// stimulus block fills. A clocked monitor runs a local copy of the counters and
// capacities at each accepted request and queues the triangles it expects. Each
// popped result is checked field by field against the oldest one. Capacity writes
// happen only once every expected result has been popped.
module tb_primitive_index_generator;
    import pig_pkg::*;

    localparam int MAX_PTS = 66;

    // opcodes outside the defined set
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [15:0]   i_cfg_data;
    logic          push;
    logic          full;
    t_req          i_req;
    logic          empty;
    logic          pop;
    t_res          o_res;

    primitive_index_generator #(
        .MAX_POINTS(MAX_PTS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .push      (push),
        .full      (full),
        .i_req     (i_req),
        .empty     (empty),
        .pop       (pop),
        .o_res     (o_res)
    );

    // Local copy of the generator state and capacity registers
    logic [15:0] vtx_pending;
    logic [15:0] idx_pending;
    logic [15:0] vtx_cap;
    logic [15:0] idx_cap;

    t_req req_backlog[$];       // requests not yet offered
    t_res tri_results_due[$];   // results predicted, oldest first
    t_res popped;

    bit   req_accepted;         // set by the monitor, consumed by the driver
    bit   idle_en;              // random bubbles on both sides
    int   gap_left;
    int   stall_left;
    int   hold_left;
    int   hold_requests;
    int   holds_served;

    int   mismatch_cnt;
    int   req_cnt;
    int   tri_cnt;
    int   full_stall_cnt;
    int   status_cnt[8];

    always #4 i_clk = ~i_clk;

    task automatic flag_mismatch(input string msg);
        mismatch_cnt++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // Works out every result one request produces and updates the counters
    function automatic void expand_primitive(input t_req r);
        t_res        res;
        int          nv;
        int          ntri;
        logic [2:0]  st;
        logic [15:0] base;
        res  = '0;
        st   = ST_OK;
        nv   = 0;
        ntri = 0;
        case (r.op)
            OP_CLEAR: begin
                vtx_pending = '0;
                idx_pending = '0;
            end
            OP_TRIANGLE: begin
                nv   = 3;
                ntri = 1;
            end
            OP_QUAD: begin
                nv   = 4;
                ntri = 2;
            end
            OP_STRIP, OP_FAN: begin
                if (r.point_count < 3)
                    st = ST_FEW;
                else if (r.point_count > MAX_PTS)
                    st = ST_MANY;
                else begin
                    nv   = int'(r.point_count);
                    ntri = int'(r.point_count) - 2;
                end
            end
            default: ;  // unknown op: status-only result, state untouched
        endcase
        // index capacity is checked before vertex capacity
        if (ntri > 0) begin
            if (int'(idx_pending) + ntri * 3 > int'(idx_cap))
                st = ST_IOVF;
            else if (int'(vtx_pending) + nv > int'(vtx_cap))
                st = ST_VOVF;
        end
        if (ntri == 0 || st != ST_OK) begin
            res.status       = st;
            res.vertex_count = vtx_pending;
            res.index_count  = idx_pending;
            res.last         = 1'b1;
            tri_results_due.push_back(res);
            return;
        end
        base        = vtx_pending;
        vtx_pending = 16'(int'(vtx_pending) + nv);
        idx_pending = 16'(int'(idx_pending) + ntri * 3);
        for (int t = 0; t < ntri; t++) begin
            res              = '0;
            res.status       = ST_OK;
            res.tri_valid    = 1'b1;
            res.base_vertex  = base;
            // strips walk the first corner; triangles, quads and fans pivot on it
            res.index_a      = (r.op == OP_STRIP) ? 16'(int'(base) + t) : base;
            res.index_b      = 16'(int'(base) + t + 1);
            res.index_c      = 16'(int'(base) + t + 2);
            res.vertex_count = vtx_pending;
            res.index_count  = idx_pending;
            res.last         = (t == ntri - 1);
            tri_results_due.push_back(res);
        end
    endfunction

    // Monitor: outputs sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                req_accepted = 1'b1;
                req_cnt++;
                expand_primitive(i_req);
            end else if (push) begin
                full_stall_cnt++;
            end
            if (pop && !empty) begin
                if (tri_results_due.size() == 0) begin
                    flag_mismatch("result popped with none due");
                end else begin
                    popped = tri_results_due.pop_front();
                    check_field("status", 16'(o_res.status), 16'(popped.status));
                    check_field("tri_valid", 16'(o_res.tri_valid), 16'(popped.tri_valid));
                    check_field("base_vertex", o_res.base_vertex, popped.base_vertex);
                    check_field("index_a", o_res.index_a, popped.index_a);
                    check_field("index_b", o_res.index_b, popped.index_b);
                    check_field("index_c", o_res.index_c, popped.index_c);
                    check_field("vertex_count", o_res.vertex_count, popped.vertex_count);
                    check_field("index_count", o_res.index_count, popped.index_count);
                    check_field("last", 16'(o_res.last), 16'(popped.last));
                end
                if (o_res.tri_valid)
                    tri_cnt++;
                status_cnt[o_res.status]++;
            end
        end
    end

    // Request driver: holds a request until it is taken, then maybe a bubble
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || req_accepted) begin
            req_accepted = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                push <= 1'b0;
            end else if (req_backlog.size() == 0) begin
                push <= 1'b0;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                gap_left = $urandom_range(1, 6) - 1;
                push <= 1'b0;
            end else begin
                i_req <= req_backlog.pop_front();
                push  <= 1'b1;
            end
        end
    end

    // Result side: random stalls, plus a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = 150;
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    task automatic add_req(input logic [2:0] op, input logic [15:0] pc);
        t_req r;
        r.op          = op;
        r.point_count = pc;
        req_backlog.push_back(r);
    endtask

    // Mostly well-formed primitives with random content; the rest is clears,
    // bad point counts and unknown ops.
    task automatic add_random_reqs(input int n);
        int mix;
        logic [2:0] op;
        for (int k = 0; k < n; k++) begin
            mix = $urandom_range(0, 99);
            op  = $urandom_range(0, 1) ? OP_STRIP : OP_FAN;
            if (mix < 60) begin
                op = 3'($urandom_range(OP_TRIANGLE, OP_FAN));
                if (op == OP_TRIANGLE || op == OP_QUAD)
                    add_req(op, 16'($urandom_range(0, 65535)));
                else if ($urandom_range(0, 4) != 0)
                    add_req(op, 16'($urandom_range(3, 10)));
                else
                    add_req(op, 16'($urandom_range(3, MAX_PTS)));
            end else if (mix < 70) begin
                add_req(OP_CLEAR, 16'($urandom_range(0, 65535)));
            end else if (mix < 80) begin
                add_req(op, 16'($urandom_range(0, 2)));
            end else if (mix < 90) begin
                add_req(op, 16'($urandom_range(MAX_PTS + 1, 65535)));
            end else begin
                add_req(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)),
                        16'($urandom_range(0, 65535)));
            end
        end
    endtask

    // Idle means: nothing waiting, nothing offered, nothing still due
    task automatic drain();
        while (req_backlog.size() != 0 || push || tri_results_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_capacities(input logic [15:0] vcap, input logic [15:0] icap);
        drain();
        repeat (2) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_VERTEX_CAP;
        i_cfg_data <= vcap;
        vtx_cap = vcap;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_INDEX_CAP;
        i_cfg_data <= icap;
        idx_cap = icap;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_VERTEX_CAP;
        i_cfg_data   = '0;
        push         = 1'b0;
        pop          = 1'b0;
        i_req        = '0;
        vtx_pending  = '0;
        idx_pending  = '0;
        vtx_cap      = VERTEX_CAP_RST;
        idx_cap      = INDEX_CAP_RST;
        idle_en      = 1'b1;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every op, point count limits, unknown ops, at reset capacities
        add_req(OP_TRIANGLE, 16'd0);
        add_req(OP_QUAD, 16'hFFFF);
        add_req(OP_STRIP, 16'd3);
        add_req(OP_STRIP, 16'(MAX_PTS));
        add_req(OP_FAN, 16'd3);
        add_req(OP_FAN, 16'(MAX_PTS));
        add_req(OP_STRIP, 16'd2);
        add_req(OP_FAN, 16'd0);
        add_req(OP_STRIP, 16'(MAX_PTS + 1));
        add_req(OP_FAN, 16'hFFFF);
        add_req(OP_UNUSED_LO, 16'd1234);
        add_req(OP_UNUSED_HI, 16'hFFFF);
        add_req(OP_CLEAR, 16'd0);

        // Vertex overflow, with index room to spare
        set_capacities(16'd7, 16'hFFFF);
        add_req(OP_TRIANGLE, 16'd0);
        add_req(OP_QUAD, 16'd0);
        add_req(OP_TRIANGLE, 16'd0);
        add_req(OP_FAN, 16'd3);

        // Capacity lowered below the pending vertex count
        set_capacities(16'd5, 16'hFFFF);
        add_req(OP_TRIANGLE, 16'd0);
        add_req(OP_CLEAR, 16'd0);
        add_req(OP_TRIANGLE, 16'd0);

        // Index overflow, with vertex room to spare
        set_capacities(16'hFFFF, 16'd3);
        add_req(OP_TRIANGLE, 16'd0);
        add_req(OP_CLEAR, 16'd0);
        add_req(OP_TRIANGLE, 16'd0);
        add_req(OP_QUAD, 16'd0);

        // Zero capacities: both checks fail, index reported
        set_capacities(16'd0, 16'd0);
        add_req(OP_TRIANGLE, 16'd0);
        add_req(OP_CLEAR, 16'd0);
        add_req(OP_STRIP, 16'd3);

        // Random phases over several capacity settings
        set_capacities(VERTEX_CAP_RST, INDEX_CAP_RST);
        add_random_reqs(35);

        // Long result hold-off while requests keep coming: fills the block
        set_capacities(16'hFFFF, 16'hFFFF);
        hold_requests++;
        add_random_reqs(40);

        set_capacities(16'($urandom_range(20, 200)), 16'($urandom_range(30, 300)));
        add_random_reqs(30);

        set_capacities(16'd0, 16'd0);
        add_random_reqs(10);

        set_capacities(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        add_random_reqs(25);

        // Final stretch with no bubbles on either side
        set_capacities(16'($urandom_range(50, 500)), 16'($urandom_range(50, 800)));
        idle_en = 1'b0;
        add_random_reqs(30);

        drain();
        repeat (10) @(negedge i_clk);

        $display("Covered %0d requests, %0d triangles; statuses ok %0d few %0d many %0d",
                 req_cnt, tri_cnt, status_cnt[ST_OK], status_cnt[ST_FEW],
                 status_cnt[ST_MANY]);
        $display("Index overflow %0d, vertex overflow %0d, %0d cycles with input held off",
                 status_cnt[ST_IOVF], status_cnt[ST_VOVF], full_stall_cnt);
        if (mismatch_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog, well above the slowest legal run
    initial begin
        #5_000_000;
        $display("Timeout: %0d results still due", tri_results_due.size());
        $display("simulation failed");
        $finish;
    end

endmodule
